// File: src/apir_pkg.sv
`default_nettype none
package apir_pkg;

  localparam logic [1:0] OP_ISSUE_RD = 2'd0;
  localparam logic [1:0] OP_ISSUE_WR = 2'd1;
  localparam logic [1:0] OP_DONE_RD  = 2'd2;
  localparam logic [1:0] OP_DONE_WR  = 2'd3;

  localparam logic [2:0] K_GRANT   = 3'd0;
  localparam logic [2:0] K_RD_RET  = 3'd1;
  localparam logic [2:0] K_WR_RET  = 3'd2;
  localparam logic [2:0] K_FULL    = 3'd3;
  localparam logic [2:0] K_BADSIZE = 3'd4;
  localparam logic [2:0] K_UNKNOWN = 3'd5;
  localparam logic [2:0] K_DUP     = 3'd6;

  typedef struct packed {
    logic load_in;
    logic do_issue;
    logic do_check;
    logic load_hc;
    logic fetch;
    logic step;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic is_done_op;
    logic out_free;
    logic cmp_err;
    logic cnt_zero;
    logic head_done;
    logic pend_valid;
  } sts_t;

endpackage
`default_nettype wire

// File: src/apir_ctrl.sv
`default_nettype none
module apir_ctrl (
  input  wire             clk,
  input  wire             rst,
  input  wire             req_valid,
  output logic            req_stall,
  input  apir_pkg::sts_t  sts,
  output apir_pkg::cmd_t  cmd
);
  import apir_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_ISSUE  = 3'd1;
  localparam logic [2:0] S_CHECK  = 3'd2;
  localparam logic [2:0] S_LOADHC = 3'd3;
  localparam logic [2:0] S_FETCH  = 3'd4;
  localparam logic [2:0] S_STEP   = 3'd5;
  localparam logic [2:0] S_FINISH = 3'd6;

  logic [2:0] state, state_next;

  assign req_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.load_in = 1'b1;
          state_next = sts.is_done_op ? S_CHECK : S_ISSUE;
        end
      end
      S_ISSUE: begin
        if (sts.out_free) begin
          cmd.do_issue = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_CHECK: begin
        if (!sts.cmp_err) begin
          cmd.do_check = 1'b1;
          state_next = S_LOADHC;
        end else if (sts.out_free) begin
          cmd.do_check = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_LOADHC: begin
        cmd.load_hc = 1'b1;
        state_next = S_FETCH;
      end
      S_FETCH: begin
        if (sts.cnt_zero) begin
          state_next = S_FINISH;
        end else begin
          cmd.fetch = 1'b1;
          state_next = S_STEP;
        end
      end
      S_STEP: begin
        if (!sts.head_done) begin
          state_next = S_FINISH;
        end else if (!sts.pend_valid || sts.out_free) begin
          cmd.step = 1'b1;
          state_next = S_FETCH;
        end
      end
      S_FINISH: begin
        if (!sts.pend_valid || sts.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule
`default_nettype wire

// File: src/apir_dp.sv
`default_nettype none
module apir_dp #(
  parameter int ID_COUNT   = 16,
  parameter int SLOT_COUNT = 16,
  parameter int BEAT_BYTES = 16
) (
  input  wire             clk,
  input  wire             rst,
  input  apir_pkg::cmd_t  cmd,
  output apir_pkg::sts_t  sts,
  input  wire  [1:0]      opcode,
  input  wire  [3:0]      trans_id,
  input  wire  [6:0]      beat_size,
  input  wire  [3:0]      done_tag,
  output logic            rsp_valid,
  input  wire             rsp_stall,
  output logic [2:0]      kind,
  output logic [3:0]      out_id,
  output logic [3:0]      out_tag,
  output logic            last
);
  import apir_pkg::*;

  localparam int SW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int IW = (ID_COUNT > 1) ? $clog2(ID_COUNT) : 1;
  localparam int CW = $clog2(SLOT_COUNT + 1);
  localparam int HW = 1 + IW;
  localparam int OW = 1 + SW;
  localparam int FW = 1 + IW + SW;

  // per-ID queue head and fill, packed as {head, count}
  logic [SW+CW-1:0] hc_mem [2**HW];
  logic [2**HW-1:0] hc_vld;
  logic [IW-1:0]    owner_mem [2**OW];
  logic [SW-1:0]    fifo_mem [2**FW];

  logic [SLOT_COUNT-1:0] busy [2];
  logic [SLOT_COUNT-1:0] done [2];

  logic          side;
  logic [3:0]    tid_q;
  logic [IW-1:0] idm_q;
  logic [6:0]    size_q;
  logic [3:0]    tag_q;
  logic [IW-1:0] owner_q;
  logic [SW+CW-1:0] hc_q;
  logic          hc_vq;
  logic [SW-1:0] fifo_q;
  logic [SW-1:0] cur_head;
  logic [CW-1:0] cur_count;
  logic          pend_valid;
  logic [SW-1:0] pend_tag;

  logic [IW-1:0] idm_in;
  logic [SW-1:0] free_slot;
  logic          free_any;
  logic [SW-1:0] hc_head;
  logic [CW-1:0] hc_cnt;
  logic [CW:0]   pos_sum;
  logic [CW:0]   pos;
  logic [SW-1:0] tag_qi;
  logic          tag_ok;
  logic          busy_t;
  logic          done_t;
  logic          bad_size;
  logic          full;
  logic          out_free;
  logic [2:0]    ret_kind;
  logic          rsp_set;

  always_comb begin
    idm_in = '0;
    for (int i = 0; i < 16; i++) begin
      if (trans_id == 4'(i)) idm_in = IW'(i % ID_COUNT);
    end
  end

  always_comb begin
    free_any = 1'b0;
    free_slot = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (!busy[side][i]) begin
        free_any = 1'b1;
        free_slot = SW'(i);
      end
    end
  end

  assign hc_head  = hc_vq ? hc_q[SW+CW-1:CW] : '0;
  assign hc_cnt   = hc_vq ? hc_q[CW-1:0] : '0;
  assign pos_sum  = (CW+1)'(hc_head) + (CW+1)'(hc_cnt);
  assign pos      = (pos_sum >= (CW+1)'(SLOT_COUNT)) ? pos_sum - (CW+1)'(SLOT_COUNT) : pos_sum;
  assign tag_qi   = SW'(tag_q);
  assign tag_ok   = (32'(tag_q) < SLOT_COUNT);
  assign busy_t   = tag_ok && busy[side][tag_qi];
  assign done_t   = tag_ok && done[side][tag_qi];
  assign bad_size = (size_q != 7'(BEAT_BYTES));
  assign full     = !free_any || (hc_cnt >= CW'(SLOT_COUNT));
  assign out_free = !rsp_valid || !rsp_stall;
  assign ret_kind = side ? K_WR_RET : K_RD_RET;
  assign rsp_set  = cmd.do_issue || (cmd.do_check && (!busy_t || done_t)) ||
                    ((cmd.step || cmd.finish) && pend_valid);

  assign sts.is_done_op = opcode[1];
  assign sts.out_free   = out_free;
  assign sts.cmp_err    = !busy_t || done_t;
  assign sts.cnt_zero   = (cur_count == '0);
  assign sts.head_done  = done[side][fifo_q];
  assign sts.pend_valid = pend_valid;

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      side   <= opcode[0];
      tid_q  <= trans_id;
      idm_q  <= idm_in;
      size_q <= beat_size;
      tag_q  <= done_tag;
      owner_q <= owner_mem[{opcode[0], SW'(done_tag)}];
      hc_q   <= hc_mem[{opcode[0], idm_in}];
      hc_vq  <= hc_vld[{opcode[0], idm_in}];
    end
    if (cmd.do_check && !(!busy_t || done_t)) begin
      hc_q  <= hc_mem[{side, owner_q}];
      hc_vq <= hc_vld[{side, owner_q}];
    end
    if (cmd.do_issue && !bad_size && !full) begin
      owner_mem[{side, free_slot}] <= idm_q;
      fifo_mem[{side, idm_q, SW'(pos)}] <= free_slot;
      hc_mem[{side, idm_q}] <= {hc_head, hc_cnt + CW'(1)};
    end
    if (cmd.load_hc) begin
      cur_head  <= hc_head;
      cur_count <= hc_cnt;
    end
    if (cmd.fetch) begin
      fifo_q <= fifo_mem[{side, owner_q, cur_head}];
    end
    if (cmd.step) begin
      pend_tag  <= fifo_q;
      cur_head  <= (cur_head == SW'(SLOT_COUNT - 1)) ? '0 : cur_head + SW'(1);
      cur_count <= cur_count - CW'(1);
    end
    if (cmd.finish) begin
      hc_mem[{side, owner_q}] <= {cur_head, cur_count};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy[0]    <= '0;
      busy[1]    <= '0;
      done[0]    <= '0;
      done[1]    <= '0;
      hc_vld     <= '0;
      pend_valid <= 1'b0;
      rsp_valid  <= 1'b0;
    end else begin
      if (rsp_set) rsp_valid <= 1'b1;
      else if (rsp_valid && !rsp_stall) rsp_valid <= 1'b0;
      if (cmd.do_issue) begin
        last <= 1'b1;
        if (bad_size) begin
          kind <= K_BADSIZE; out_id <= tid_q; out_tag <= '0;
        end else if (full) begin
          kind <= K_FULL; out_id <= tid_q; out_tag <= '0;
        end else begin
          kind <= K_GRANT; out_id <= 4'(idm_q); out_tag <= 4'(free_slot);
          busy[side][free_slot] <= 1'b1;
          done[side][free_slot] <= 1'b0;
          hc_vld[{side, idm_q}] <= 1'b1;
        end
      end
      if (cmd.do_check) begin
        if (!busy_t) begin
          last <= 1'b1;
          kind <= K_UNKNOWN; out_id <= '0; out_tag <= tag_q;
        end else if (done_t) begin
          last <= 1'b1;
          kind <= K_DUP; out_id <= 4'(owner_q); out_tag <= tag_q;
        end else begin
          done[side][tag_qi] <= 1'b1;
        end
      end
      if (cmd.load_hc) pend_valid <= 1'b0;
      if (cmd.step) begin
        busy[side][fifo_q] <= 1'b0;
        done[side][fifo_q] <= 1'b0;
        pend_valid <= 1'b1;
        if (pend_valid) begin
          last <= 1'b0;
          kind <= ret_kind; out_id <= 4'(owner_q); out_tag <= 4'(pend_tag);
        end
      end
      if (cmd.finish) begin
        hc_vld[{side, owner_q}] <= 1'b1;
        pend_valid <= 1'b0;
        if (pend_valid) begin
          last <= 1'b1;
          kind <= ret_kind; out_id <= 4'(owner_q); out_tag <= 4'(pend_tag);
        end
      end
    end
  end

endmodule
`default_nettype wire

// File: src/axi_per_id_inorder_retire.sv
// Channel  Valid      Stall      Beat fields
// req      req_valid  req_stall  opcode, trans_id, beat_size, done_tag
// rsp      rsp_valid  rsp_stall  kind, out_id, out_tag, last
//
// An issue reads the queue state, then updates it and replies.
// A completion checks the tag, loads the ID queue state, walks the queue and
// writes it back; an unknown or duplicate tag is answered at the check. The
// ID queue is walked one entry at a time through the order memory's read port.
// req_stall stays high from acceptance until the last beat is loaded.
// Reset clears the slot tables and queue-state valid bits.
// A stalled rsp holds its beat; the walk pauses until it is taken.
`default_nettype none
module axi_per_id_inorder_retire #(
  parameter int ID_COUNT   = 16,
  parameter int SLOT_COUNT = 16,
  parameter int BEAT_BYTES = 16
) (
  input  wire        clk,
  input  wire        rst,
  input  wire        req_valid,
  output logic       req_stall,
  input  wire  [1:0] opcode,
  input  wire  [3:0] trans_id,
  input  wire  [6:0] beat_size,
  input  wire  [3:0] done_tag,
  output logic       rsp_valid,
  input  wire        rsp_stall,
  output logic [2:0] kind,
  output logic [3:0] out_id,
  output logic [3:0] out_tag,
  output logic       last
);
  import apir_pkg::*;

  cmd_t cmd;
  sts_t sts;

  apir_ctrl u_ctrl (
    .clk(clk), .rst(rst), .req_valid(req_valid), .req_stall(req_stall),
    .sts(sts), .cmd(cmd)
  );

  apir_dp #(
    .ID_COUNT(ID_COUNT), .SLOT_COUNT(SLOT_COUNT), .BEAT_BYTES(BEAT_BYTES)
  ) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts),
    .opcode(opcode), .trans_id(trans_id), .beat_size(beat_size),
    .done_tag(done_tag), .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
    .kind(kind), .out_id(out_id), .out_tag(out_tag), .last(last)
  );

endmodule
`default_nettype wire

// File: src/apir_chk.sv
`default_nettype none
module apir_chk (
  input wire       clk,
  input wire       rst,
  input wire       req_valid,
  input wire       req_stall,
  input wire       rsp_valid,
  input wire       rsp_stall,
  input wire [2:0] kind,
  input wire [3:0] out_id,
  input wire [3:0] out_tag,
  input wire       last
);
  import apir_pkg::*;

  a_rst_idle: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("rsp beat right after reset");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> req_stall)
    else $error("request taken while previous one in flight");

  a_single_last: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && kind != K_RD_RET && kind != K_WR_RET) |-> last)
    else $error("grant or error beat without last");

  a_kind_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> kind <= K_DUP)
    else $error("undefined kind");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(kind) && $stable(out_tag)))
    else $error("stalled rsp beat changed");

endmodule

bind axi_per_id_inorder_retire apir_chk u_apir_chk (
  .clk(clk), .rst(rst), .req_valid(req_valid), .req_stall(req_stall),
  .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .kind(kind),
  .out_id(out_id), .out_tag(out_tag), .last(last)
);
`default_nettype wire
